### rtl/rvi_pkg.sv
package rvi_pkg;

    localparam int MEM_BYTES_DEF = 65536;

    // Input word function codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISALIGN = 3'd1;
    localparam logic [2:0] ST_BOUNDS   = 3'd2;
    localparam logic [2:0] ST_ILLEGAL  = 3'd3;
    localparam logic [2:0] ST_HALTED   = 3'd4;

    // Major opcodes.
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct3 codes used by the sequencer.
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
        ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
    } t_alu_op;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_EXEC, S_NEXT, S_LOAD, S_RESP
    } t_state;

    function automatic t_alu_op alu_sel(input logic [2:0] f3, input logic alt);
        t_alu_op op;
        case (f3)
            F3_ADD:  op = alt ? ALU_SUB : ALU_ADD;
            F3_SLL:  op = ALU_SLL;
            F3_SLT:  op = ALU_SLT;
            F3_SLTU: op = ALU_SLTU;
            F3_XOR:  op = ALU_XOR;
            F3_SR:   op = alt ? ALU_SRA : ALU_SRL;
            F3_OR:   op = ALU_OR;
            default: op = ALU_AND;
        endcase
        return op;
    endfunction

    function automatic logic [31:0] imm_i(input logic [31:0] ins);
        return {{20{ins[31]}}, ins[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] ins);
        return {{20{ins[31]}}, ins[31:25], ins[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] ins);
        return {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_u(input logic [31:0] ins);
        return {ins[31:12], 12'h000};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] ins);
        return {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    endfunction

endpackage

### rtl/rvi_alu.sv
// Shared arithmetic, compare and shift unit.
module rvi_alu (
    input  rvi_pkg::t_alu_op i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic [31:0]      o_y
);

    always_comb begin
        case (i_op)
            rvi_pkg::ALU_ADD:  o_y = i_a + i_b;
            rvi_pkg::ALU_SUB:  o_y = i_a - i_b;
            rvi_pkg::ALU_SLL:  o_y = i_a << i_b[4:0];
            rvi_pkg::ALU_SLT:  o_y = {31'd0, $signed(i_a) < $signed(i_b)};
            rvi_pkg::ALU_SLTU: o_y = {31'd0, i_a < i_b};
            rvi_pkg::ALU_XOR:  o_y = i_a ^ i_b;
            rvi_pkg::ALU_SRL:  o_y = i_a >> i_b[4:0];
            rvi_pkg::ALU_SRA:  o_y = $unsigned($signed(i_a) >>> i_b[4:0]);
            rvi_pkg::ALU_OR:   o_y = i_a | i_b;
            rvi_pkg::ALU_AND:  o_y = i_a & i_b;
            default:           o_y = i_a + i_b;
        endcase
    end

endmodule

### rtl/rvi_regfile.sv
// 32 x 32 register file, one write port and two registered read ports.
// A valid bit per entry makes unwritten entries read as zero after reset.
module rvi_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we && i_waddr != 5'd0) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_waddr != 5'd0) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_qa <= r_mem[i_raddr_a];
        r_qb <= r_mem[i_raddr_b];
        r_va <= r_vld[i_raddr_a];
        r_vb <= r_vld[i_raddr_b];
    end

    assign o_rdata_a = r_va ? r_qa : 32'd0;
    assign o_rdata_b = r_vb ? r_qb : 32'd0;

endmodule

### rtl/rvi_mem.sv
// Word-wide data memory with byte enables and a registered read port.
module rvi_mem #(
    parameter int NWORDS = 16384,
    parameter int AW     = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [3:0]    i_be,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [NWORDS];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_we && i_be[k]) begin
                r_mem[i_waddr][8*k +: 8] <= i_wdata[8*k +: 8];
            end
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/rv32i_instruction_step.sv
// Channel | Direction | Handshake          | Word
// input   | in        | i_valid / o_stall  | i_func, i_load_word_index, i_load_word
// result  | out       | o_valid / i_stall  | o_status, o_next_pc, o_wrote_register,
//         |           |                    | o_dest_register, o_dest_value,
//         |           |                    | o_store_valid, o_store_address, o_store_data
//
// A program load word goes from the idle state straight to the result. A step word
// passes through fetch from the single memory read port, register read, one pass
// through the shared unit for the operation or address, a second pass for the next
// program counter, then the data memory access for loads, the result and the idle state.
// Faults and halted steps end early: a halted step or a bad program counter is reported
// from idle, an illegal instruction after the first pass, a bad access after the second.
// After reset the memory is cleared one word a cycle, and no input word is taken
// until the clear is done. A stalled result holds and blocks new input.
module rv32i_instruction_step #(
    parameter int MEM_BYTES = rvi_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [13:0] i_load_word_index,
    input  logic [31:0] i_load_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_next_pc,
    output logic        o_wrote_register,
    output logic [4:0]  o_dest_register,
    output logic [31:0] o_dest_value,
    output logic        o_store_valid,
    output logic [15:0] o_store_address,
    output logic [31:0] o_store_data
);

    localparam int NWORDS = (MEM_BYTES + 3) / 4;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    rvi_pkg::t_state r_state, n_state;
    logic [31:0]   r_pc, n_pc;
    logic          r_halted, n_halted;
    logic [AW-1:0] r_clr, n_clr;
    logic [31:0]   r_ins, n_ins;
    logic [31:0]   r_res, n_res;
    logic [2:0]    r_status, n_status;
    logic [31:0]   r_opc, n_opc;
    logic          r_wrote, n_wrote;
    logic [4:0]    r_dest, n_dest;
    logic [31:0]   r_dval, n_dval;
    logic          r_stv, n_stv;
    logic [15:0]   r_sta, n_sta;
    logic [31:0]   r_std, n_std;

    rvi_pkg::t_alu_op w_op;
    logic [31:0]   w_a, w_b, w_y;
    logic          w_mwe;
    logic [3:0]    w_mbe;
    logic [AW-1:0] w_mwa, w_mra;
    logic [31:0]   w_mwd, w_mrd;
    logic          w_rwe;
    logic [4:0]    w_rwa, w_rra, w_rrb;
    logic [31:0]   w_rwd, w_rfa, w_rfb;
    logic [31:0]   w_idx32;
    logic [6:0]    w_opc;
    logic [2:0]    w_f3;
    logic [4:0]    w_rd;
    logic [2:0]    w_acc_st;
    logic [32:0]   w_end;
    logic [31:0]   w_lsh;
    logic          w_taken;

    rvi_alu u_alu (.i_op(w_op), .i_a(w_a), .i_b(w_b), .o_y(w_y));

    rvi_mem #(.NWORDS(NWORDS), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_mwe), .i_be(w_mbe), .i_waddr(w_mwa),
        .i_wdata(w_mwd), .i_raddr(w_mra), .o_rdata(w_mrd)
    );

    rvi_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(w_rwe), .i_waddr(w_rwa),
        .i_wdata(w_rwd), .i_raddr_a(w_rra), .i_raddr_b(w_rrb),
        .o_rdata_a(w_rfa), .o_rdata_b(w_rfb)
    );

    assign o_stall = (r_state != rvi_pkg::S_IDLE);
    assign o_valid = (r_state == rvi_pkg::S_RESP);
    assign o_status = r_status;
    assign o_next_pc = r_opc;
    assign o_wrote_register = r_wrote;
    assign o_dest_register = r_dest;
    assign o_dest_value = r_dval;
    assign o_store_valid = r_stv;
    assign o_store_address = r_sta;
    assign o_store_data = r_std;

    assign w_idx32 = {18'd0, i_load_word_index};
    assign w_opc = r_ins[6:0];
    assign w_f3 = r_ins[14:12];
    assign w_rd = r_ins[11:7];

    // Register reads take their indexes from the fetched word while it arrives,
    // then from the held instruction so the read data stays put.
    assign w_rra = (r_state == rvi_pkg::S_FETCH) ? w_mrd[19:15] : r_ins[19:15];
    assign w_rrb = (r_state == rvi_pkg::S_FETCH) ? w_mrd[24:20] : r_ins[24:20];

    // The memory read port serves the fetch at the program counter and the
    // data read at the computed address.
    assign w_mra = (r_state == rvi_pkg::S_NEXT) ? r_res[AW+1:2] : r_pc[AW+1:2];

    // Access check on the address held in r_res: alignment first, then bounds.
    always_comb begin
        w_end = {1'b0, r_res} + ((w_f3[1:0] == 2'd0) ? 33'd1 :
                                 (w_f3[1:0] == 2'd1) ? 33'd2 : 33'd4);
        if ((w_f3[1:0] == 2'd1 && r_res[0]) ||
            (w_f3[1:0] == 2'd2 && r_res[1:0] != 2'd0)) begin
            w_acc_st = rvi_pkg::ST_MISALIGN;
        end else if (w_end > MEM_LIMIT) begin
            w_acc_st = rvi_pkg::ST_BOUNDS;
        end else begin
            w_acc_st = rvi_pkg::ST_OK;
        end
    end

    // Branch outcome from the compare that the first pass left in r_res.
    always_comb begin
        case (w_f3)
            rvi_pkg::F3_BEQ:  w_taken = (r_res == 32'd0);
            rvi_pkg::F3_BNE:  w_taken = (r_res != 32'd0);
            rvi_pkg::F3_BLT:  w_taken = r_res[0];
            rvi_pkg::F3_BLTU: w_taken = r_res[0];
            rvi_pkg::F3_BGE:  w_taken = !r_res[0];
            rvi_pkg::F3_BGEU: w_taken = !r_res[0];
            default:          w_taken = 1'b0;
        endcase
    end

    assign w_lsh = w_mrd >> {r_res[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rvi_pkg::S_CLEAR;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_halted <= n_halted;
            r_clr    <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins    <= n_ins;
        r_res    <= n_res;
        r_status <= n_status;
        r_opc    <= n_opc;
        r_wrote  <= n_wrote;
        r_dest   <= n_dest;
        r_dval   <= n_dval;
        r_stv    <= n_stv;
        r_sta    <= n_sta;
        r_std    <= n_std;
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_halted = r_halted;
        n_clr    = r_clr;
        n_ins    = r_ins;
        n_res    = r_res;
        n_status = r_status;
        n_opc    = r_opc;
        n_wrote  = r_wrote;
        n_dest   = r_dest;
        n_dval   = r_dval;
        n_stv    = r_stv;
        n_sta    = r_sta;
        n_std    = r_std;
        w_op  = rvi_pkg::ALU_ADD;
        w_a   = r_pc;
        w_b   = 32'd4;
        w_mwe = 1'b0;
        w_mbe = 4'b1111;
        w_mwa = r_clr;
        w_mwd = 32'd0;
        w_rwe = 1'b0;
        w_rwa = w_rd;
        w_rwd = r_res;

        case (r_state)
            rvi_pkg::S_CLEAR: begin
                w_mwe = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_WORD) begin
                    n_state = rvi_pkg::S_IDLE;
                end
            end

            rvi_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_status = rvi_pkg::ST_OK;
                    n_opc    = r_pc;
                    n_wrote  = 1'b0;
                    n_dest   = 5'd0;
                    n_dval   = 32'd0;
                    n_stv    = 1'b0;
                    n_sta    = 16'd0;
                    n_std    = 32'd0;
                    n_state  = rvi_pkg::S_RESP;
                    if (i_func == rvi_pkg::FUNC_LOAD) begin
                        // Program load; a word past the end is refused.
                        if ({1'b0, w_idx32[29:0], 2'b00} + 33'd4 > MEM_LIMIT) begin
                            n_status = rvi_pkg::ST_BOUNDS;
                        end else begin
                            w_mwe = 1'b1;
                            w_mwa = w_idx32[AW-1:0];
                            w_mwd = i_load_word;
                        end
                    end else if (r_halted) begin
                        n_status = rvi_pkg::ST_HALTED;
                    end else if (r_pc[1:0] != 2'd0) begin
                        n_status = rvi_pkg::ST_MISALIGN;
                        n_halted = 1'b1;
                    end else if ({1'b0, r_pc} + 33'd4 > MEM_LIMIT) begin
                        n_status = rvi_pkg::ST_BOUNDS;
                        n_halted = 1'b1;
                    end else begin
                        n_state = rvi_pkg::S_FETCH;
                    end
                end
            end

            rvi_pkg::S_FETCH: begin
                n_ins   = w_mrd;
                n_state = rvi_pkg::S_EXEC;
            end

            rvi_pkg::S_EXEC: begin
                // First pass: operation result, effective address or compare.
                n_state = rvi_pkg::S_NEXT;
                case (w_opc)
                    rvi_pkg::OPC_LUI: begin
                        w_a = 32'd0;
                        w_b = rvi_pkg::imm_u(r_ins);
                    end
                    rvi_pkg::OPC_AUIPC: begin
                        w_b = rvi_pkg::imm_u(r_ins);
                    end
                    rvi_pkg::OPC_JAL: begin
                        w_b = 32'd4;
                    end
                    rvi_pkg::OPC_JALR: begin
                        w_a = w_rfa;
                        w_b = rvi_pkg::imm_i(r_ins);
                    end
                    rvi_pkg::OPC_BRANCH: begin
                        w_a = w_rfa;
                        w_b = w_rfb;
                        if (w_f3[2:1] == 2'b00) begin
                            w_op = rvi_pkg::ALU_XOR;
                        end else if (w_f3[2:1] == 2'b10) begin
                            w_op = rvi_pkg::ALU_SLT;
                        end else if (w_f3[2:1] == 2'b11) begin
                            w_op = rvi_pkg::ALU_SLTU;
                        end else begin
                            n_state = rvi_pkg::S_RESP;
                        end
                    end
                    rvi_pkg::OPC_LOAD: begin
                        w_a = w_rfa;
                        w_b = rvi_pkg::imm_i(r_ins);
                        if (w_f3 != rvi_pkg::F3_LB && w_f3 != rvi_pkg::F3_LH &&
                            w_f3 != rvi_pkg::F3_LW && w_f3 != rvi_pkg::F3_LBU &&
                            w_f3 != rvi_pkg::F3_LHU) begin
                            n_state = rvi_pkg::S_RESP;
                        end
                    end
                    rvi_pkg::OPC_STORE: begin
                        w_a = w_rfa;
                        w_b = rvi_pkg::imm_s(r_ins);
                        if (w_f3 != rvi_pkg::F3_SB && w_f3 != rvi_pkg::F3_SH &&
                            w_f3 != rvi_pkg::F3_SW) begin
                            n_state = rvi_pkg::S_RESP;
                        end
                    end
                    rvi_pkg::OPC_OPIMM: begin
                        w_a  = w_rfa;
                        w_b  = rvi_pkg::imm_i(r_ins);
                        w_op = rvi_pkg::alu_sel(w_f3, w_f3 == rvi_pkg::F3_SR && r_ins[30]);
                    end
                    rvi_pkg::OPC_OP: begin
                        w_a  = w_rfa;
                        w_b  = w_rfb;
                        w_op = rvi_pkg::alu_sel(w_f3, r_ins[30]);
                    end
                    rvi_pkg::OPC_FENCE, rvi_pkg::OPC_SYSTEM: begin
                        w_b = 32'd4;
                    end
                    default: begin
                        n_state = rvi_pkg::S_RESP;
                    end
                endcase
                if (n_state == rvi_pkg::S_RESP) begin
                    n_status = rvi_pkg::ST_ILLEGAL;
                    n_halted = 1'b1;
                end
                n_res = w_y;
            end

            rvi_pkg::S_NEXT: begin
                // Second pass: program counter plus step or offset.
                n_state = rvi_pkg::S_RESP;
                if (w_opc == rvi_pkg::OPC_JAL) begin
                    w_b = rvi_pkg::imm_j(r_ins);
                end else if (w_opc == rvi_pkg::OPC_BRANCH && w_taken) begin
                    w_b = rvi_pkg::imm_b(r_ins);
                end
                if ((w_opc == rvi_pkg::OPC_LOAD || w_opc == rvi_pkg::OPC_STORE) &&
                    w_acc_st != rvi_pkg::ST_OK) begin
                    n_status = w_acc_st;
                    n_halted = 1'b1;
                end else begin
                    n_pc  = (w_opc == rvi_pkg::OPC_JALR) ? {r_res[31:1], 1'b0} : w_y;
                    n_opc = n_pc;
                    if (w_opc == rvi_pkg::OPC_LOAD) begin
                        n_state = rvi_pkg::S_LOAD;
                    end else if (w_opc == rvi_pkg::OPC_STORE) begin
                        w_mwe = 1'b1;
                        w_mwa = r_res[AW+1:2];
                        n_stv = 1'b1;
                        n_sta = r_res[15:0];
                        if (w_f3 == rvi_pkg::F3_SB) begin
                            w_mwd = {4{w_rfb[7:0]}};
                            w_mbe = 4'b0001 << r_res[1:0];
                            n_std = {24'd0, w_rfb[7:0]};
                        end else if (w_f3 == rvi_pkg::F3_SH) begin
                            w_mwd = {2{w_rfb[15:0]}};
                            w_mbe = r_res[1] ? 4'b1100 : 4'b0011;
                            n_std = {16'd0, w_rfb[15:0]};
                        end else begin
                            w_mwd = w_rfb;
                            n_std = w_rfb;
                        end
                    end else if (w_opc == rvi_pkg::OPC_LUI || w_opc == rvi_pkg::OPC_AUIPC ||
                                 w_opc == rvi_pkg::OPC_JAL || w_opc == rvi_pkg::OPC_JALR ||
                                 w_opc == rvi_pkg::OPC_OPIMM || w_opc == rvi_pkg::OPC_OP) begin
                        w_rwd = (w_opc == rvi_pkg::OPC_JALR) ? w_y : r_res;
                        if (w_rd != 5'd0) begin
                            w_rwe   = 1'b1;
                            n_wrote = 1'b1;
                            n_dest  = w_rd;
                            n_dval  = w_rwd;
                        end
                    end
                end
            end

            rvi_pkg::S_LOAD: begin
                n_state = rvi_pkg::S_RESP;
                case (w_f3)
                    rvi_pkg::F3_LB:  w_rwd = {{24{w_lsh[7]}}, w_lsh[7:0]};
                    rvi_pkg::F3_LH:  w_rwd = {{16{w_lsh[15]}}, w_lsh[15:0]};
                    rvi_pkg::F3_LBU: w_rwd = {24'd0, w_lsh[7:0]};
                    rvi_pkg::F3_LHU: w_rwd = {16'd0, w_lsh[15:0]};
                    default:         w_rwd = w_mrd;
                endcase
                if (w_rd != 5'd0) begin
                    w_rwe   = 1'b1;
                    n_wrote = 1'b1;
                    n_dest  = w_rd;
                    n_dval  = w_rwd;
                end
            end

            rvi_pkg::S_RESP: begin
                if (!i_stall) begin
                    n_state = rvi_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rvi_pkg::S_IDLE;
            end
        endcase
    end

    // A faulted or halted result never carries a register or memory write.
    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rvi_pkg::ST_OK) |-> (!o_wrote_register && !o_store_valid))
        else $error("fault result carries a write");

    a_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_wrote_register) |-> (o_dest_register != 5'd0))
        else $error("write reported for register zero");

    // The core stays halted once set, until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halted) && $past(i_rst_n) |-> r_halted)
        else $error("halted flag dropped without reset");

    // A faulting step leaves the program counter where it was; this checks misaligned, illegal and halted steps.
    a_fault_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rvi_pkg::ST_MISALIGN || o_status == rvi_pkg::ST_ILLEGAL ||
                     o_status == rvi_pkg::ST_HALTED)) |-> (o_next_pc == r_pc))
        else $error("program counter moved on a fault");

endmodule
